@@ hw/rtl/bpfa_pkg.sv @@
// Package for the bitmap page frame allocator: sizes, register indexes,
// request codes and the command/status structs between controller and datapath.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

  // Geometry of the managed frame space.
  localparam int NUM_FRAMES  = 4096;
  localparam int PAGE_BITS   = 12;
  localparam int WORD_BITS   = 32;
  localparam int BMP_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = $clog2(BMP_WORDS);
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int FRAME_IDX_W = WORD_IDX_W + BIT_IDX_W;
  localparam int WCNT_W      = $clog2(BMP_WORDS + 1);

  // Field and register widths.
  localparam int ADDR_W     = 32;
  localparam int LIMIT_W    = 13;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [ADDR_W-1:0]  BASE_RESET  = ADDR_W'(1048576);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
  localparam logic [ADDR_W-1:0]  FIRST_RESET = ADDR_W'(1048576);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIM  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ADDR = CFG_IDX_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLAIM = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef struct packed {
    logic load;      // capture the request item
    logic decode;    // translate the address into a frame index
    logic read;      // read the bitmap word of the decoded frame
    logic modify;    // update the word and form the status bits
    logic scan;      // one step of the first-fit search
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_alloc;   // the offered request is an allocate
    logic scan_done;  // the search found a frame or ran out of words
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpfa_bitmap_mem.sv @@
// Availability bitmap storage: one write port, one registered read port.
// Each row has a valid bit cleared by reset, so unwritten rows read as zero.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_bitmap_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [bpfa_pkg::WORD_IDX_W-1:0] waddr_i,
  input  logic [bpfa_pkg::WORD_BITS-1:0]  wdata_i,
  input  logic                            re_i,
  input  logic [bpfa_pkg::WORD_IDX_W-1:0] raddr_i,
  output logic [bpfa_pkg::WORD_BITS-1:0]  rdata_o
);
  import bpfa_pkg::*;

  logic [WORD_BITS-1:0] mem_q [BMP_WORDS];
  logic [BMP_WORDS-1:0] row_vld_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        row_vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= row_vld_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/bpfa_datapath.sv @@
// Datapath of the allocator: configuration registers, request registers,
// address decode, bitmap update, first-fit scan and the output register.
// Depends on bpfa_pkg and bpfa_bitmap_mem.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [bpfa_pkg::FUNC_W-1:0]     func_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]     frame_addr_i,
  input  bpfa_pkg::ctrl_cmd_t             cmd_i,
  output bpfa_pkg::dp_status_t            status_o,
  output logic [bpfa_pkg::ADDR_W-1:0]     result_addr_o,
  output logic                            success_o,
  output logic                            range_error_o
);
  import bpfa_pkg::*;

  logic [ADDR_W-1:0]      base_q, first_q;
  logic [LIMIT_W-1:0]     limit_q;
  func_e                  func_q;
  logic [ADDR_W-1:0]      addr_q;
  logic                   inr_q, ok_q, rerr_q;
  logic                   ok_d, rerr_d;
  logic [FRAME_IDX_W-1:0] idx_q, idx_d;
  logic [WCNT_W-1:0]      rd_ptr_q;
  logic                   pend_q;
  logic [WORD_IDX_W-1:0]  chk_w_q;
  logic [ADDR_W-1:0]      res_addr_q;
  logic                   success_q, range_err_q;

  logic [LIMIT_W-1:0]     eff_lim;
  logic [LIMIT_W:0]       lim_round;
  logic [WCNT_W-1:0]      nwords;
  logic [ADDR_W-1:0]      diff, idx_full;
  logic                   inr_d;

  logic                   mem_we, mem_re;
  logic [WORD_IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]   mem_wdata, rdata;

  logic [WORD_BITS-1:0]   sel_oh, word_mask, masked, hit_oh;
  logic [LIMIT_W-1:0]     remain;
  logic [BIT_IDX_W-1:0]   hit_bit;
  logic                   hit, more_words, sel_bit;
  logic [ADDR_W-1:0]      alloc_addr;

  // Frames above the build size are never managed.
  assign eff_lim   = (limit_q > LIMIT_W'(NUM_FRAMES)) ? LIMIT_W'(NUM_FRAMES) : limit_q;
  assign lim_round = {1'b0, eff_lim} + (LIMIT_W + 1)'(WORD_BITS - 1);
  assign nwords    = lim_round[BIT_IDX_W +: WCNT_W];

  assign diff     = addr_q - base_q;
  assign idx_full = diff >> PAGE_BITS;
  assign inr_d    = (addr_q >= base_q) && (idx_full < ADDR_W'(eff_lim));

  // Single word update for free, claim and query.
  assign sel_oh  = WORD_BITS'(1) << idx_q[BIT_IDX_W-1:0];
  assign sel_bit = |(rdata & sel_oh);

  // Scan: keep only the bits of this word that lie below the frame limit.
  assign remain    = eff_lim - LIMIT_W'({chk_w_q, {BIT_IDX_W{1'b0}}});
  assign word_mask = (remain >= LIMIT_W'(WORD_BITS)) ? '1
                   : ~({WORD_BITS{1'b1}} << remain[BIT_IDX_W-1:0]);
  assign masked    = rdata & word_mask;
  assign hit       = pend_q && (|masked);
  assign hit_oh    = WORD_BITS'(1) << hit_bit;
  assign more_words = (rd_ptr_q < nwords);

  // Lowest set bit of the masked word.
  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        hit_bit = BIT_IDX_W'(i);
      end
    end
  end

  assign status_o.in_alloc  = (func_i == FUNC_ALLOC);
  assign status_o.scan_done = hit || (!pend_q && !more_words);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[FRAME_IDX_W-1:BIT_IDX_W];
    mem_wdata = rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_q[FRAME_IDX_W-1:BIT_IDX_W];
    ok_d      = ok_q;
    rerr_d    = rerr_q;
    idx_d     = idx_q;
    if (cmd_i.decode) begin
      idx_d = idx_full[FRAME_IDX_W-1:0];
    end
    if (cmd_i.read) begin
      mem_re = 1'b1;
    end
    if (cmd_i.modify) begin
      case (func_q)
        FUNC_FREE: begin
          if (addr_q != '0) begin
            if (inr_q) begin
              mem_we    = 1'b1;
              mem_wdata = rdata | sel_oh;
            end else begin
              rerr_d = 1'b1;
            end
          end
        end
        FUNC_CLAIM: begin
          if (!inr_q) begin
            rerr_d = 1'b1;
          end else if ((addr_q > first_q) && sel_bit) begin
            mem_we    = 1'b1;
            mem_wdata = rdata & ~sel_oh;
            ok_d      = 1'b1;
          end
        end
        FUNC_QUERY: begin
          if (!inr_q) begin
            rerr_d = 1'b1;
          end else begin
            ok_d = sel_bit;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.scan) begin
      mem_raddr = rd_ptr_q[WORD_IDX_W-1:0];
      mem_re    = more_words;
      if (hit) begin
        mem_we    = 1'b1;
        mem_waddr = chk_w_q;
        mem_wdata = rdata & ~hit_oh;
        idx_d     = {chk_w_q, hit_bit};
        ok_d      = 1'b1;
      end
    end
  end

  assign alloc_addr = base_q + (ADDR_W'(idx_q) << PAGE_BITS);

  bpfa_bitmap_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Configuration and scan control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RESET;
      limit_q  <= LIMIT_RESET;
      first_q  <= FIRST_RESET;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE_ADDR:  base_q  <= cfg_data_i[ADDR_W-1:0];
          CFG_FRAME_LIM:  limit_q <= cfg_data_i[LIMIT_W-1:0];
          CFG_FIRST_ADDR: first_q <= cfg_data_i[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load) begin
        rd_ptr_q <= '0;
        pend_q   <= 1'b0;
      end else if (cmd_i.scan) begin
        pend_q <= more_words;
        if (more_words) begin
          rd_ptr_q <= rd_ptr_q + WCNT_W'(1);
        end
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      addr_q <= frame_addr_i;
      ok_q   <= 1'b0;
      rerr_q <= 1'b0;
    end else begin
      ok_q   <= ok_d;
      rerr_q <= rerr_d;
    end
    idx_q <= idx_d;
    if (cmd_i.decode) begin
      inr_q <= inr_d;
    end
    if (cmd_i.scan && more_words) begin
      chk_w_q <= rd_ptr_q[WORD_IDX_W-1:0];
    end
    if (cmd_i.out_load) begin
      if (func_q == FUNC_ALLOC) begin
        res_addr_q <= ok_q ? alloc_addr : '0;
      end else begin
        res_addr_q <= addr_q;
      end
      success_q   <= ok_q;
      range_err_q <= rerr_q;
    end
  end

  assign result_addr_o = res_addr_q;
  assign success_o     = success_q;
  assign range_error_o = range_err_q;

endmodule

`default_nettype wire

@@ hw/rtl/bpfa_ctrl.sv @@
// Controller of the allocator: sequences decode, read-modify-write and the
// first-fit scan, and owns the input ready and output valid handshakes.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bpfa_pkg::dp_status_t status_i,
  output bpfa_pkg::ctrl_cmd_t  cmd_o
);
  import bpfa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_alloc ? ST_SCAN : ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !out_ready_i) || cmd_o.out_load;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_page_frame_allocator.sv @@
// Top level of the bitmap first-fit page frame allocator.
// Joins the controller and the datapath; depends on bpfa_pkg and both modules.
//
// Usage: a request item (func_i, frame_addr_i) enters on in_valid_i/in_ready_o
// and one result item (result_addr_o, success_o, range_error_o) leaves on
// out_valid_o/out_ready_i. Requests are handled one at a time. Free, claim
// and query step through decode, bitmap read, update, and the output load;
// the next request is taken once the block is back in idle. Allocate walks
// the bitmap one 32-bit word per cycle through the single read port of the
// bitmap memory, and stops at the first word that holds an available frame
// below the frame limit, or after the last word when none is available. A
// finished result sits in the output register; the block accepts the next
// request while it waits, and finishes that request only once the output
// register has been taken. Configuration writes on cfg_we_i land in the same
// cycle and are to be made only while no request is in flight.
// Reset returns the registers to their defaults and marks every frame used:
// per-row valid bits make the whole bitmap read as zero at once, so there is
// no clearing pass and the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_frame_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bpfa_pkg::FUNC_W-1:0]     func_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]     frame_addr_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bpfa_pkg::ADDR_W-1:0]     result_addr_o,
  output logic                            success_o,
  output logic                            range_error_o
);
  import bpfa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller only sequences; all request data stays in the datapath.
  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the bitmap and the result register.
  bpfa_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .frame_addr_i  (frame_addr_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .result_addr_o (result_addr_o),
    .success_o     (success_o),
    .range_error_o (range_error_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bpfa_checker.sv @@
// Port-level checks for the page frame allocator and the bind that attaches
// them to the top level. Depends on bpfa_pkg and bitmap_page_frame_allocator.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bpfa_pkg::ADDR_W-1:0]   result_addr_o,
  input logic                          success_o,
  input logic                          range_error_o
);
  import bpfa_pkg::*;

  // One request at a time: after an item is taken the input closes.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready stayed high after an accepted item");

  // A new result only appears after the block was busy with a request.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a request in flight");

  // An out-of-range address never reports success.
  a_range_no_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> !success_o)
    else $error("range error reported together with success");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_addr_o)
      && $stable(success_o) && $stable(range_error_o))
    else $error("stalled result changed");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_addr_o (result_addr_o),
  .success_o     (success_o),
  .range_error_o (range_error_o)
);

`default_nettype wire
